### hw/rtl/scld_pkg.sv
`timescale 1ns / 1ps

package scld_pkg;

	localparam int ENTRIES   = 16;
	localparam int TAG_W     = 24;
	localparam int SLOT_W    = 4;
	localparam int CAP_W     = 5;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int CAP_RESET = 16;
	localparam int CAP_MIN   = 2;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [IDX_W-1:0] home;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic cmp_en;
		logic shift_en;
	} cell_ctrl_t;

	// capacity clamped to CAP_MIN..ENTRIES
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		if (int'(c) < CAP_MIN) begin
			return CNT_W'(CAP_MIN);
		end else if (int'(c) > ENTRIES) begin
			return CNT_W'(ENTRIES);
		end else begin
			return CNT_W'(c);
		end
	endfunction

endpackage

### hw/rtl/scld_cell.sv
`timescale 1ns / 1ps

module scld_cell
	import scld_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [TAG_W-1:0] key,
	input  entry_t           nbr,
	output entry_t           entry,
	output logic             valid,
	output logic             match
);

	entry_t entry_q;
	logic   valid_q;
	logic   match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.shift_en)
				valid_q <= 1'b1;
			if (ctrl.cmp_en)
				match_q <= valid_q && (entry_q.tag == key);
		end
	end

	// position in the row is recency rank; a shift takes the neighbour's entry
	always_ff @(posedge clk) begin
		if (ctrl.shift_en)
			entry_q <= nbr;
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign match = match_q;

endmodule

### hw/rtl/segment_cache_lru_directory.sv
`timescale 1ns / 1ps
// Fully associative segment directory with LRU replacement.
// Request channel (in_valid/in_ready): segment_number and fetch_ok, one beat
// per lookup. Result channel (out_valid/out_ready): hit, slot, stored,
// evicted, evicted_number, one beat per request.
// Config channel (cfg_valid/cfg_ready): writes capacity and empties the
// store in the same cycle; the user must see that it is only written while
// no request is in flight, as the block does not enforce this.
// Entries sit in a row of cells ordered by recency, most recent first; a
// hit, install or eviction shifts the cells in front of the target by one.
// The tag compare is registered in the cells on the request beat, then the
// shift and the result register follow; the next request is not taken until
// the held one completes, and in_ready is low from a beat until then.
// Reset: store empty, capacity 16, no result pending.
// A stalled result holds in the output register; the pending request then
// waits in the row and the next request is not taken until it completes.
module segment_cache_lru_directory
	import scld_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TAG_W-1:0]  segment_number,
	input  logic              fetch_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic [SLOT_W-1:0] slot,
	output logic              stored,
	output logic              evicted,
	output logic [TAG_W-1:0]  evicted_number,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data
);

	entry_t           entry_w [ENTRIES];
	entry_t           nbr_w   [ENTRIES];
	cell_ctrl_t       ctrl_w  [ENTRIES];
	logic [ENTRIES-1:0] match_w;
	logic [ENTRIES-1:0] valid_w;

	logic             v_s1;
	logic [TAG_W-1:0] seg_s1;
	logic             ok_s1;

	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;

	logic              out_valid_q;
	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic              stored_q;
	logic              evicted_q;
	logic [TAG_W-1:0]  evicted_number_q;

	logic             in_fire;
	logic             cfg_fire;
	logic             fire;
	logic             hit_w;
	logic             full_w;
	logic             evict_w;
	logic             insert_w;
	logic             upd_w;
	logic [CNT_W-1:0] cap_eff;
	logic [IDX_W-1:0] p_hit;
	logic [IDX_W-1:0] target;
	logic [IDX_W-1:0] new_home;
	entry_t           sel_w;

	assign in_ready  = ~v_s1;
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid & in_ready;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign fire      = v_s1 & (~out_valid_q | out_ready);

	assign hit_w    = |match_w;
	assign cap_eff  = eff_cap(capacity_q);
	assign full_w   = count_q >= cap_eff;
	assign evict_w  = ~hit_w & ok_s1 & full_w;
	assign insert_w = ~hit_w & ok_s1 & ~full_w;
	assign upd_w    = fire & (hit_w | ok_s1);

	always_comb begin
		p_hit = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_w[i])
				p_hit = p_hit | IDX_W'(i);
		end
	end

	always_comb begin
		target = p_hit;
		if (evict_w)
			target = IDX_W'(count_q - CNT_W'(1));
		else if (insert_w)
			target = IDX_W'(count_q);
	end

	assign sel_w    = entry_w[target];
	assign new_home = insert_w ? IDX_W'(count_q) : sel_w.home;

	assign nbr_w[0] = '{tag: seg_s1, home: new_home};

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			if (g > 0) begin : g_nbr
				assign nbr_w[g] = entry_w[g-1];
			end
			assign ctrl_w[g] = '{clear: cfg_fire, cmp_en: in_fire,
				shift_en: upd_w & (IDX_W'(g) <= target)};
			scld_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl_w[g]),
				.key   (segment_number),
				.nbr   (nbr_w[g]),
				.entry (entry_w[g]),
				.valid (valid_w[g]),
				.match (match_w[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			capacity_q  <= CAP_W'(CAP_RESET);
			count_q     <= '0;
		end else begin
			if (in_fire)
				v_s1 <= 1'b1;
			else if (fire)
				v_s1 <= 1'b0;
			if (fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_fire) begin
				capacity_q <= cfg_data;
				count_q    <= '0;
			end else if (fire && insert_w) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			seg_s1 <= segment_number;
			ok_s1  <= fetch_ok;
		end
		if (fire) begin
			hit_q            <= hit_w;
			stored_q         <= hit_w | ok_s1;
			slot_q           <= (hit_w | ok_s1) ? SLOT_W'(new_home) : '0;
			evicted_q        <= evict_w;
			evicted_number_q <= evict_w ? sel_w.tag : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign slot           = slot_q;
	assign stored         = stored_q;
	assign evicted        = evicted_q;
	assign evicted_number = evicted_number_q;

`ifndef NO_ASSERTIONS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_cap(capacity_q))
		else $error("occupancy above capacity");

	a_match_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_w))
		else $error("segment held by more than one cell");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("valid cells disagree with occupancy");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && evict_w |=> evicted && stored && !hit)
		else $error("eviction result lost");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import scld_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD      = 120;
	localparam int DRAIN_CYCLES   = 4;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              stored;
		logic              evicted;
		logic [TAG_W-1:0]  evicted_number;
	} lookup_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [TAG_W-1:0]  segment_number;
	logic              fetch_ok;
	logic              out_valid;
	logic              out_ready;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              stored;
	logic              evicted;
	logic [TAG_W-1:0]  evicted_number;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data;

	// directory mirror
	logic [TAG_W-1:0] dir_tag [ENTRIES];
	bit               dir_valid [ENTRIES];
	int               dir_rank [ENTRIES];
	int               dir_count;
	logic [CAP_W-1:0] cap_reg;

	lookup_result_t pending_lookups[$];

	int tx_idle_pct;
	int rx_stall_pct;
	bit hold_toggle;
	bit hold_seen;
	int fail_count;
	int idle_cycles;
	int beats_in;
	int beats_hit;
	int beats_evict;
	int beats_refused;
	int cap_writes;

	logic [TAG_W-1:0] seg_pool[$];

	segment_cache_lru_directory uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.segment_number (segment_number),
		.fetch_ok       (fetch_ok),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.hit            (hit),
		.slot           (slot),
		.stored         (stored),
		.evicted        (evicted),
		.evicted_number (evicted_number),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_directory();
		for (int i = 0; i < ENTRIES; i++) begin
			dir_tag[i]   = '0;
			dir_valid[i] = 1'b0;
			dir_rank[i]  = 0;
		end
		dir_count = 0;
	endfunction

	function automatic lookup_result_t lru_lookup(input logic [TAG_W-1:0] seg, input bit ok);
		lookup_result_t r;
		bit found;
		int where;
		int worst;
		int old_rank;
		int limit;
		r = '0;
		found = 1'b0;
		where = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!found && dir_valid[i] && dir_tag[i] == seg) begin
				found = 1'b1;
				where = i;
			end
		end
		if (found) begin
			old_rank = dir_rank[where];
			for (int i = 0; i < ENTRIES; i++)
				if (dir_valid[i] && dir_rank[i] < old_rank)
					dir_rank[i]++;
			dir_rank[where] = 0;
			r.hit    = 1'b1;
			r.stored = 1'b1;
			r.slot   = SLOT_W'(where);
		end else if (ok) begin
			limit = int'(cap_reg);
			if (limit < CAP_MIN)
				limit = CAP_MIN;
			if (limit > ENTRIES)
				limit = ENTRIES;
			if (dir_count >= limit) begin
				worst = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (dir_valid[i] && (worst < 0 || dir_rank[i] > dir_rank[worst]))
						worst = i;
				if (worst >= 0) begin
					r.evicted        = 1'b1;
					r.evicted_number = dir_tag[worst];
					dir_valid[worst] = 1'b0;
					dir_count--;
				end
			end
			where = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (where < 0 && !dir_valid[i])
					where = i;
			if (where < 0)
				where = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (dir_valid[i])
					dir_rank[i]++;
			dir_valid[where] = 1'b1;
			dir_tag[where]   = seg;
			dir_rank[where]  = 0;
			dir_count++;
			r.stored = 1'b1;
			r.slot   = SLOT_W'(where);
		end
		return r;
	endfunction

	// valid is left high after a beat when the next beat follows at once
	task automatic send_lookup(input logic [TAG_W-1:0] seg, input bit ok);
		in_valid       <= 1'b1;
		segment_number <= seg;
		fetch_ok       <= ok;
		do begin
			@(posedge clk);
			if (!in_ready)
				beats_refused++;
		end while (!in_ready);
		pending_lookups.push_back(lru_lookup(seg, ok));
		beats_in++;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = value;
		clear_directory();
		cap_writes++;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		lookup_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lookups.size() == 0) begin
				$error("result beat with no lookup outstanding");
				fail_count++;
			end else begin
				want = pending_lookups.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					fail_count++;
				end
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					fail_count++;
				end
				if (stored !== want.stored) begin
					$error("stored: expected %0d, got %0d", want.stored, stored);
					fail_count++;
				end
				if (evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, evicted);
					fail_count++;
				end
				if (evicted_number !== want.evicted_number) begin
					$error("evicted_number: expected %h, got %h",
						want.evicted_number, evicted_number);
					fail_count++;
				end
				if (want.hit)
					beats_hit++;
				if (want.evicted)
					beats_evict++;
			end
		end
	end

	initial begin
		hold_seen = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic test_directed_basic();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_lookup(24'h000000, 1'b1);
		send_lookup(24'hFFFFFF, 1'b1);
		send_lookup(24'h000000, 1'b0);
		send_lookup(24'h123456, 1'b0);
		send_lookup(24'hFFFFFF, 1'b0);
		send_lookup(24'h123456, 1'b1);
		wait_idle();
	endtask

	task automatic test_directed_eviction();
		write_capacity(5'd2);
		send_lookup(24'h000001, 1'b1);
		send_lookup(24'h000002, 1'b1);
		send_lookup(24'h000001, 1'b1);
		send_lookup(24'h000003, 1'b1);
		send_lookup(24'h000004, 1'b0);
		send_lookup(24'h000005, 1'b1);
		write_capacity(5'd0);
		send_lookup(24'hAAAAAA, 1'b1);
		send_lookup(24'h555555, 1'b1);
		send_lookup(24'h800000, 1'b1);
		send_lookup(24'hAAAAAA, 1'b1);
		wait_idle();
	endtask

	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		write_capacity(5'd4);
		hold_toggle = ~hold_toggle;
		for (int i = 0; i < 20; i++)
			send_lookup(TAG_W'(i % 6), 1'b1);
		wait_idle();
	endtask

	task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int count,
		input int tx_pct, input int rx_pct);
		logic [TAG_W-1:0] seg;
		bit ok;
		int pick;
		write_capacity(cap);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		seg_pool.delete();
		repeat (int'(cap) % 20 + 4)
			seg_pool.push_back(TAG_W'($urandom));
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 75)
				seg = seg_pool[$urandom_range(seg_pool.size() - 1)];
			else if (pick < 80)
				seg = {TAG_W{1'b1}};
			else
				seg = TAG_W'($urandom);
			ok = ($urandom_range(99) < 85);
			send_lookup(seg, ok);
		end
		wait_idle();
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		segment_number <= '0;
		fetch_ok       <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_data       <= '0;
		hold_toggle    = 1'b0;
		tx_idle_pct    = 0;
		rx_stall_pct   = 0;
		fail_count     = 0;
		idle_cycles    = 0;
		beats_in       = 0;
		beats_hit      = 0;
		beats_evict    = 0;
		beats_refused  = 0;
		cap_writes     = 0;
		cap_reg        = CAP_W'(CAP_RESET);
		clear_directory();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basic();
		test_directed_eviction();
		test_backpressure();
		test_random_phase(5'd16, 60, 0, 0);
		test_random_phase(5'd4, 120, 73, 0);
		test_random_phase(5'd31, 120, 0, 73);
		test_random_phase(5'd1, 80, 6, 6);
		test_random_phase(5'd9, 100, 0, 0);
		test_random_phase(5'd0, 80, 73, 0);
		test_random_phase(5'd17, 100, 0, 73);
		test_random_phase(5'($urandom_range(2, 16)), 60, 6, 6);
		wait_idle();

		$display("covered %0d lookups: %0d hits, %0d evictions, %0d capacity writes",
			beats_in, beats_hit, beats_evict, cap_writes);
		$display("input held off for %0d cycles while busy or stalled", beats_refused);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

### sim.f
hw/rtl/scld_pkg.sv
hw/rtl/scld_cell.sv
hw/rtl/segment_cache_lru_directory.sv
verif/testbench.sv
